// ===== rtl/fst_pkg.sv =====
package fst_pkg;

  // Default coordinate width in bits (signed fixed point).
  localparam int COORD_WIDTH_DEF = 32;

  // Multiplier digit width: the narrow operand is consumed this many bits per cycle.
  localparam int DIG = 8;

  // The work matrix has nine entries.
  localparam int WK_N  = 9;
  localparam int WK_IW = $clog2(WK_N);

  // Slot that triggers a solve.
  localparam logic [1:0] SLOT_SOLVE = 2'd3;

  // Last step indices of the two product sequences.
  localparam logic [1:0] SQ_LAST  = 2'd3;
  localparam logic [3:0] DET_LAST = 4'd8;

  // Solve phases: the plain determinant first, then one per column.
  localparam logic [1:0] PH_DET  = 2'd0;
  localparam logic [1:0] PH_LAST = 2'd3;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SING = 2'd1,
    ST_SAT  = 2'd2,
    ST_INC  = 2'd3
  } stat_t;

  // Operand sources of the shared multiplier.
  typedef enum logic [2:0] {
    SRC_WK   = 3'd0,
    SRC_TACC = 3'd1,
    SRC_CX   = 3'd2,
    SRC_CY   = 3'd3,
    SRC_CZ   = 3'd4,
    SRC_CR   = 3'd5
  } src_t;

  // Accumulator that receives a product.
  typedef enum logic [1:0] {
    DST_T = 2'd0,
    DST_D = 2'd1,
    DST_S = 2'd2
  } dst_t;

  // How a product is merged into its accumulator.
  typedef enum logic [1:0] {
    MD_SET = 2'd0,
    MD_ADD = 2'd1,
    MD_SUB = 2'd2
  } mode_t;

  // One product step.
  typedef struct packed {
    src_t              asel;
    logic [WK_IW-1:0]  aidx;
    src_t              bsel;
    logic [WK_IW-1:0]  bidx;
    dst_t              dst;
    mode_t             mode;
  } mstep_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        capture;
    logic        mul_start;
    mstep_t      step;
    logic        sq_store;
    logic        wk_load;
    logic [1:0]  wk_col;
    logic        det_store;
    logic        div_start;
    logic        pos_store;
    logic [1:0]  pos_idx;
    logic        emit;
    stat_t       code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_solve;
    logic mask_full;
    logic mul_done;
    logic div_done;
    logic det_zero;
  } dp_sts_t;

  function automatic mstep_t mk_step(src_t asel, logic [WK_IW-1:0] aidx, src_t bsel,
                                     logic [WK_IW-1:0] bidx, dst_t dst, mode_t mode);
    mstep_t s;
    s.asel = asel;
    s.aidx = aidx;
    s.bsel = bsel;
    s.bidx = bidx;
    s.dst  = dst;
    s.mode = mode;
    return s;
  endfunction

  // Squared norm less squared radius of the captured sphere.
  function automatic mstep_t sq_step(logic [1:0] i);
    mstep_t s;
    case (i)
      2'd0:    s = mk_step(SRC_CX, '0, SRC_CX, '0, DST_S, MD_SET);
      2'd1:    s = mk_step(SRC_CY, '0, SRC_CY, '0, DST_S, MD_ADD);
      2'd2:    s = mk_step(SRC_CZ, '0, SRC_CZ, '0, DST_S, MD_ADD);
      default: s = mk_step(SRC_CR, '0, SRC_CR, '0, DST_S, MD_SUB);
    endcase
    return s;
  endfunction

  // Cofactor expansion of the work matrix along its first row.
  function automatic mstep_t det_step(logic [3:0] i);
    mstep_t s;
    case (i)
      4'd0:    s = mk_step(SRC_WK,   4'd4, SRC_WK, 4'd8, DST_T, MD_SET);
      4'd1:    s = mk_step(SRC_WK,   4'd5, SRC_WK, 4'd7, DST_T, MD_SUB);
      4'd2:    s = mk_step(SRC_TACC, 4'd0, SRC_WK, 4'd0, DST_D, MD_SET);
      4'd3:    s = mk_step(SRC_WK,   4'd3, SRC_WK, 4'd8, DST_T, MD_SET);
      4'd4:    s = mk_step(SRC_WK,   4'd5, SRC_WK, 4'd6, DST_T, MD_SUB);
      4'd5:    s = mk_step(SRC_TACC, 4'd0, SRC_WK, 4'd1, DST_D, MD_SUB);
      4'd6:    s = mk_step(SRC_WK,   4'd3, SRC_WK, 4'd7, DST_T, MD_SET);
      4'd7:    s = mk_step(SRC_WK,   4'd4, SRC_WK, 4'd6, DST_T, MD_SUB);
      default: s = mk_step(SRC_TACC, 4'd0, SRC_WK, 4'd2, DST_D, MD_ADD);
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/four_sphere_trilateration.sv =====
// Four-sphere trilateration.
// A transaction is accepted at a rising edge with start high and busy low. It
// carries one sphere: its slot, centre (signed fixed point) and radius (unsigned). Slots 0
// to 2 are stored; slot 3 solves for the common point against the stored spheres
// and itself, and gives exactly one result, shown on the out_ ports for a single
// cycle with out_valid high. The receiver cannot stall, so no result is held back.
// Work is done by one shared multiplier, which takes its narrow (2*CW+3)-bit
// operand in ND = ceil((2*CW+3)/8) digits of 8 bits, and by a divider that takes one
// quotient bit per cycle over 4*CW+8 bits. A load takes 4 products. A solve takes
// 40 products and three divisions, and its result is on the out_ ports in the
// first cycle in which busy is low again. An incomplete set or a singular matrix
// ends early.
// busy stays high for the whole of that work. Reset clears the loaded-sphere mask
// and the controller; stored spheres are not cleared, and a solve before all
// three are loaded reports the incomplete status.
module four_sphere_trilateration #(
  parameter int COORD_WIDTH = fst_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_sphere_slot,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic [COORD_WIDTH-2:0]        in_radius,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_pos_x,
  output logic signed [COORD_WIDTH-1:0] out_pos_y,
  output logic signed [COORD_WIDTH-1:0] out_pos_z,
  output logic [1:0]                    out_status
);
  import fst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer of the product, division and result steps.
  fst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Sphere storage, arithmetic units and the result register.
  fst_dp #(.CW(COORD_WIDTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sphere_slot (in_sphere_slot),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_center_z    (in_center_z),
    .in_radius      (in_radius),
    .out_valid      (out_valid),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_status     (out_status)
  );

endmodule

// ===== rtl/fst_mul.sv =====
module fst_mul #(
  parameter int WW = 136,
  parameter int NB = 67
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [WW-1:0] a,
  input  logic [NB-1:0] b,
  output logic          done,
  output logic [WW-1:0] p
);
  import fst_pkg::*;

  localparam int ND = (NB + DIG - 1) / DIG;
  localparam int CW = $clog2(ND + 1);

  logic [WW-1:0] a_r, acc_r, p_r;
  logic [NB-1:0] bm_r;
  logic          neg_r, run_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [WW-1:0] part, acc_nxt;

  // One digit of the magnitude of b per cycle; the product is exact modulo 2^WW.
  assign part    = a_r * WW'(bm_r[DIG-1:0]);
  assign acc_nxt = acc_r + part;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        bm_r  <= b[NB-1] ? (~b + NB'(1)) : b;
        neg_r <= b[NB-1];
        acc_r <= '0;
        cnt_r <= CW'(ND);
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= acc_nxt;
        a_r   <= a_r << DIG;
        bm_r  <= bm_r >> DIG;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          p_r    <= neg_r ? (~acc_nxt + WW'(1)) : acc_nxt;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ===== rtl/fst_div.sv =====
module fst_div #(
  parameter int WW = 136,
  parameter int W  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [WW-1:0] num,
  input  logic [WW-1:0] den,
  output logic          done,
  output logic [W-1:0]  quo,
  output logic          sat
);
  localparam int CW = $clog2(WW + 1);

  logic [WW-1:0] nmag_r, dmag_r, rem_r, q_r;
  logic          neg_r, run_r, fin_r, done_r, sat_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  quo_r;
  logic [WW:0]   rem_sh, rem_dif;
  logic          ge;
  logic [WW-1:0] lim;
  logic [W-1:0]  mag;
  logic          over;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign rem_sh  = {rem_r, nmag_r[WW-1]};
  assign rem_dif = rem_sh - {1'b0, dmag_r};
  assign ge      = !rem_dif[WW];

  // Clamp to the signed coordinate range.
  assign lim  = (WW'(1) << (W - 1)) - (neg_r ? WW'(0) : WW'(1));
  assign over = q_r > lim;
  assign mag  = over ? lim[W-1:0] : q_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        nmag_r <= num[WW-1] ? (~num + WW'(1)) : num;
        dmag_r <= den[WW-1] ? (~den + WW'(1)) : den;
        neg_r  <= num[WW-1] ^ den[WW-1];
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= CW'(WW);
        run_r  <= 1'b1;
      end else if (run_r) begin
        rem_r  <= ge ? rem_dif[WW-1:0] : rem_sh[WW-1:0];
        q_r    <= {q_r[WW-2:0], ge};
        nmag_r <= nmag_r << 1;
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
        sat_r  <= over;
        quo_r  <= neg_r ? (~mag + W'(1)) : mag;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign sat  = sat_r;

endmodule

// ===== rtl/fst_dp.sv =====
module fst_dp #(
  parameter int CW = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fst_pkg::dp_cmd_t       cmd,
  output fst_pkg::dp_sts_t       sts,
  input  logic [1:0]             in_sphere_slot,
  input  logic signed [CW-1:0]   in_center_x,
  input  logic signed [CW-1:0]   in_center_y,
  input  logic signed [CW-1:0]   in_center_z,
  input  logic [CW-2:0]          in_radius,
  output logic                   out_valid,
  output logic signed [CW-1:0]   out_pos_x,
  output logic signed [CW-1:0]   out_pos_y,
  output logic signed [CW-1:0]   out_pos_z,
  output logic [1:0]             out_status
);
  import fst_pkg::*;

  localparam int NB = 2 * CW + 3;
  localparam int WW = 4 * CW + 8;

  // Captured sphere of the current transaction.
  logic [1:0]            cur_slot_r;
  logic signed [CW-1:0]  cur_x_r, cur_y_r, cur_z_r;
  logic [CW-2:0]         cur_r_r;

  // Stored spheres 0 to 2.
  logic signed [CW-1:0]  st_x_r [3];
  logic signed [CW-1:0]  st_y_r [3];
  logic signed [CW-1:0]  st_z_r [3];
  logic [2:0]            mask_r;

  logic signed [NB-1:0]  sq_r [4];
  logic signed [NB-1:0]  wk_r [WK_N];
  logic signed [WW-1:0]  tacc_r, dacc_r, det_r;
  logic signed [NB-1:0]  sacc_r;
  dst_t                  pend_dst_r;
  mode_t                 pend_mode_r;
  logic [CW-1:0]         pos_r [3];
  logic                  sat_r;

  logic                  out_valid_r;
  logic [CW-1:0]         out_x_r, out_y_r, out_z_r;
  stat_t                 out_st_r;

  logic signed [CW-1:0]  ctr [4][3];
  logic signed [CW:0]    mdif [3][3];
  logic signed [NB-1:0]  rhs [3];
  logic [WW-1:0]         opa;
  logic [NB-1:0]         opb;
  logic                  mul_done, div_done, div_sat;
  logic [WW-1:0]         mul_p;
  logic [CW-1:0]         div_q;
  logic                  emit_ok;

  function automatic logic [WW-1:0] merge(logic [WW-1:0] old, logic [WW-1:0] p, mode_t m);
    logic [WW-1:0] r;
    case (m)
      MD_ADD:  r = old + p;
      MD_SUB:  r = old - p;
      default: r = p;
    endcase
    return r;
  endfunction

  // Centres of the four spheres; sphere 3 is the one just captured.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctr[k][0] = st_x_r[k];
      ctr[k][1] = st_y_r[k];
      ctr[k][2] = st_z_r[k];
    end
    ctr[3][0] = cur_x_r;
    ctr[3][1] = cur_y_r;
    ctr[3][2] = cur_z_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mdif[r][c] = (CW+1)'(ctr[r+1][c]) - (CW+1)'(ctr[0][c]);
      end
      rhs[r] = sq_r[r+1] - sq_r[0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.step.asel)
      SRC_WK:   opa = WW'(wk_r[cmd.step.aidx]);
      SRC_TACC: opa = tacc_r;
      SRC_CX:   opa = WW'(cur_x_r);
      SRC_CY:   opa = WW'(cur_y_r);
      SRC_CZ:   opa = WW'(cur_z_r);
      SRC_CR:   opa = WW'(cur_r_r);
      default:  opa = '0;
    endcase
    case (cmd.step.bsel)
      SRC_WK:  opb = wk_r[cmd.step.bidx];
      SRC_CX:  opb = NB'(cur_x_r);
      SRC_CY:  opb = NB'(cur_y_r);
      SRC_CZ:  opb = NB'(cur_z_r);
      SRC_CR:  opb = NB'(cur_r_r);
      default: opb = '0;
    endcase
  end

  fst_mul #(.WW(WW), .NB(NB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .p     (mul_p)
  );

  fst_div #(.WW(WW), .W(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dacc_r),
    .den   (det_r << 1),
    .done  (div_done),
    .quo   (div_q),
    .sat   (div_sat)
  );

  // Capture of a transaction; slots 0 to 2 are stored at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cmd.capture && in_sphere_slot != SLOT_SOLVE) begin
      mask_r[in_sphere_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_slot_r <= in_sphere_slot;
      cur_x_r    <= in_center_x;
      cur_y_r    <= in_center_y;
      cur_z_r    <= in_center_z;
      cur_r_r    <= in_radius;
      if (in_sphere_slot != SLOT_SOLVE) begin
        st_x_r[in_sphere_slot] <= in_center_x;
        st_y_r[in_sphere_slot] <= in_center_y;
        st_z_r[in_sphere_slot] <= in_center_z;
      end
    end
  end

  // Accumulators, work matrix and stored results.
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      pend_dst_r  <= cmd.step.dst;
      pend_mode_r <= cmd.step.mode;
    end
    if (mul_done) begin
      case (pend_dst_r)
        DST_T:   tacc_r <= merge(tacc_r, mul_p, pend_mode_r);
        DST_D:   dacc_r <= merge(dacc_r, mul_p, pend_mode_r);
        default: sacc_r <= NB'(merge(WW'(sacc_r), mul_p, pend_mode_r));
      endcase
    end
    if (cmd.sq_store) begin
      sq_r[cur_slot_r] <= sacc_r;
    end
    if (cmd.wk_load) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          wk_r[3*r+c] <= (cmd.wk_col == 2'(c)) ? rhs[r] : NB'(mdif[r][c]);
        end
      end
    end
    if (cmd.det_store) begin
      det_r <= dacc_r;
    end
    if (cmd.pos_store) begin
      pos_r[cmd.pos_idx] <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.capture) begin
      sat_r <= 1'b0;
    end else if (cmd.pos_store && div_sat) begin
      sat_r <= 1'b1;
    end
  end

  // Result register: out_valid is high for a single cycle per solve.
  assign emit_ok = cmd.code == ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r  <= emit_ok ? pos_r[0] : '0;
      out_y_r  <= emit_ok ? pos_r[1] : '0;
      out_z_r  <= emit_ok ? pos_r[2] : '0;
      out_st_r <= (emit_ok && sat_r) ? ST_SAT : cmd.code;
    end
  end

  assign sts.cur_solve = cur_slot_r == SLOT_SOLVE;
  assign sts.mask_full = &mask_r;
  assign sts.mul_done  = mul_done;
  assign sts.div_done  = div_done;
  assign sts.det_zero  = dacc_r == '0;

  assign out_valid  = out_valid_r;
  assign out_pos_x  = out_x_r;
  assign out_pos_y  = out_y_r;
  assign out_pos_z  = out_z_r;
  assign out_status = out_st_r;

endmodule

// ===== rtl/fst_ctrl.sv =====
module fst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fst_pkg::dp_sts_t  sts,
  output fst_pkg::dp_cmd_t  cmd
);
  import fst_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SQ      = 8'b0000_0010,
    S_SQ_END  = 8'b0000_0100,
    S_WK_LOAD = 8'b0000_1000,
    S_DET     = 8'b0001_0000,
    S_DET_END = 8'b0010_0000,
    S_DIV     = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        wait_r, wait_nxt;
  logic [1:0]  phase_r, phase_nxt;
  stat_t       code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      wait_r  <= 1'b0;
      phase_r <= PH_DET;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      wait_r  <= wait_nxt;
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    wait_nxt  = wait_r;
    phase_nxt = phase_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.step  = det_step(step_r);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          step_nxt    = '0;
          wait_nxt    = 1'b0;
          state_nxt   = S_SQ;
        end
      end
      // Squared norm less squared radius of the captured sphere, one product at a time.
      S_SQ: begin
        cmd.step = sq_step(step_r[1:0]);
        if (!wait_r) begin
          cmd.mul_start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (sts.mul_done) begin
          wait_nxt = 1'b0;
          if (step_r[1:0] == SQ_LAST) begin
            state_nxt = S_SQ_END;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      S_SQ_END: begin
        cmd.sq_store = 1'b1;
        if (!sts.cur_solve) begin
          state_nxt = S_IDLE;
        end else if (!sts.mask_full) begin
          code_nxt  = ST_INC;
          state_nxt = S_EMIT;
        end else begin
          phase_nxt = PH_DET;
          state_nxt = S_WK_LOAD;
        end
      end
      // Phase 0 loads the plain matrix; the column code then matches no column.
      S_WK_LOAD: begin
        cmd.wk_load = 1'b1;
        cmd.wk_col  = phase_r - 2'd1;
        step_nxt    = '0;
        wait_nxt    = 1'b0;
        state_nxt   = S_DET;
      end
      S_DET: begin
        if (!wait_r) begin
          cmd.mul_start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (sts.mul_done) begin
          wait_nxt = 1'b0;
          if (step_r == DET_LAST) begin
            state_nxt = S_DET_END;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      S_DET_END: begin
        if (phase_r == PH_DET) begin
          cmd.det_store = 1'b1;
          if (sts.det_zero) begin
            code_nxt  = ST_SING;
            state_nxt = S_EMIT;
          end else begin
            phase_nxt = phase_r + 2'd1;
            state_nxt = S_WK_LOAD;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.pos_store = 1'b1;
          cmd.pos_idx   = phase_r - 2'd1;
          if (phase_r == PH_LAST) begin
            code_nxt  = ST_OK;
            state_nxt = S_EMIT;
          end else begin
            phase_nxt = phase_r + 2'd1;
            state_nxt = S_WK_LOAD;
          end
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.code  = code_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

// ===== sim/four_sphere_trilateration_test.sv =====
module four_sphere_trilateration_test;
  import fst_pkg::*;

  localparam int CW = 32;

  typedef logic signed [255:0] wide_t;
  typedef wide_t mat_t [9];

  typedef struct {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    stat_t                st;
  } point_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_sphere_slot;
  logic signed [CW-1:0] in_center_x;
  logic signed [CW-1:0] in_center_y;
  logic signed [CW-1:0] in_center_z;
  logic [CW-2:0]        in_radius;
  logic                 out_valid;
  logic signed [CW-1:0] out_pos_x;
  logic signed [CW-1:0] out_pos_y;
  logic signed [CW-1:0] out_pos_z;
  logic [1:0]           out_status;

  // Model copy of the stored spheres.
  logic signed [CW-1:0] sph_x [3];
  logic signed [CW-1:0] sph_y [3];
  logic signed [CW-1:0] sph_z [3];
  logic [CW-2:0]        sph_r [3];
  logic [2:0]           sph_loaded;

  point_t expected_points [$];
  int     mismatches;

  four_sphere_trilateration #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sphere_slot(in_sphere_slot), .in_center_x(in_center_x),
    .in_center_y(in_center_y), .in_center_z(in_center_z), .in_radius(in_radius),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  // Determinant by cofactor expansion along the first row.
  function automatic wide_t det3(mat_t m);
    return m[0] * (m[4] * m[8] - m[5] * m[7])
         - m[1] * (m[3] * m[8] - m[5] * m[6])
         + m[2] * (m[3] * m[7] - m[4] * m[6]);
  endfunction

  // Truncated quotient, clamped to the coordinate range.
  function automatic logic signed [CW-1:0] clamp_div(wide_t num, wide_t den, ref logic sat);
    wide_t q, hi, lo;
    hi = (wide_t'(1) <<< (CW-1)) - wide_t'(1);
    lo = -(wide_t'(1) <<< (CW-1));
    q = num / den;
    if (q > hi) begin
      sat = 1'b1;
      return {1'b0, {(CW-1){1'b1}}};
    end else if (q < lo) begin
      sat = 1'b1;
      return {1'b1, {(CW-1){1'b0}}};
    end
    return q[CW-1:0];
  endfunction

  function automatic wide_t norm_less_r2(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                         logic signed [CW-1:0] z, logic [CW-2:0] r);
    wide_t wx, wy, wz, wr;
    wx = x;
    wy = y;
    wz = z;
    wr = $signed({{(256-CW+1){1'b0}}, r});
    return wx * wx + wy * wy + wz * wz - wr * wr;
  endfunction

  // Update the stored spheres or work out the solved point for one transaction.
  task automatic predict_sphere(logic [1:0] slot, logic signed [CW-1:0] x,
                                logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                                logic [CW-2:0] r);
    point_t p;
    mat_t   m, mc;
    wide_t  rhs [3];
    wide_t  s0, det;
    wide_t  cx [4], cy [4], cz [4];
    logic   sat;
    logic signed [CW-1:0] pos [3];
    if (slot != SLOT_SOLVE) begin
      sph_x[slot] = x;
      sph_y[slot] = y;
      sph_z[slot] = z;
      sph_r[slot] = r;
      sph_loaded[slot] = 1'b1;
      return;
    end
    p.px = '0;
    p.py = '0;
    p.pz = '0;
    if (sph_loaded != 3'b111) begin
      p.st = ST_INC;
      expected_points.push_back(p);
      return;
    end
    for (int k = 0; k < 3; k++) begin
      cx[k] = sph_x[k];
      cy[k] = sph_y[k];
      cz[k] = sph_z[k];
    end
    cx[3] = x;
    cy[3] = y;
    cz[3] = z;
    s0 = norm_less_r2(sph_x[0], sph_y[0], sph_z[0], sph_r[0]);
    for (int k = 1; k < 4; k++) begin
      m[(k-1)*3]   = cx[k] - cx[0];
      m[(k-1)*3+1] = cy[k] - cy[0];
      m[(k-1)*3+2] = cz[k] - cz[0];
      if (k < 3)
        rhs[k-1] = norm_less_r2(sph_x[k], sph_y[k], sph_z[k], sph_r[k]) - s0;
      else
        rhs[k-1] = norm_less_r2(x, y, z, r) - s0;
    end
    det = det3(m);
    if (det == 0) begin
      p.st = ST_SING;
      expected_points.push_back(p);
      return;
    end
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mc = m;
      for (int k = 0; k < 3; k++) mc[k*3+i] = rhs[k];
      pos[i] = clamp_div(det3(mc), det + det, sat);
    end
    p.px = pos[0];
    p.py = pos[1];
    p.pz = pos[2];
    p.st = sat ? ST_SAT : ST_OK;
    expected_points.push_back(p);
  endtask

  // Offer one sphere after a random gap and hold it until the block takes it.
  task automatic send_sphere(logic [1:0] slot, logic signed [CW-1:0] x,
                             logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                             logic [CW-2:0] r);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_sphere_slot <= slot;
    in_center_x    <= x;
    in_center_y    <= y;
    in_center_z    <= z;
    in_radius      <= r;
    do @(posedge clk); while (busy);
    predict_sphere(slot, x, y, z, r);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2**21)) - 2**20;
      2: return $signed($urandom_range(0, 2**11)) - 2**10;
      default: case ($urandom_range(0, 3))
        0: return {1'b0, {(CW-1){1'b1}}};
        1: return {1'b1, {(CW-1){1'b0}}};
        2: return '0;
        default: return -1;
      endcase
    endcase
  endfunction

  function automatic logic [CW-2:0] rand_radius(int kind);
    case (kind)
      0: return (CW-1)'($urandom);
      1: return (CW-1)'($urandom_range(0, 2**21));
      2: return (CW-1)'($urandom_range(0, 2**11));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_random(logic [1:0] slot, int kind);
    send_sphere(slot, rand_coord(kind), rand_coord(kind), rand_coord(kind),
                rand_radius(kind));
  endtask

  // Wait until every expected result has been seen.
  task automatic drain;
    start <= 1'b0;
    while (expected_points.size() != 0 || busy) @(posedge clk);
  endtask

  // Result checker: compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %h %h %h status %0d",
                                       out_pos_x, out_pos_y, out_pos_z, out_status);
      end else begin
        e = expected_points.pop_front();
        if (out_pos_x !== e.px || out_pos_y !== e.py || out_pos_z !== e.pz ||
            out_status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h status %0d, got %h %h %h status %0d",
                     e.px, e.py, e.pz, e.st, out_pos_x, out_pos_y, out_pos_z, out_status);
        end
      end
    end
  end

  // A solve before the set is loaded, and after only part of it.
  task automatic test_incomplete;
    send_random(SLOT_SOLVE, 1);
    send_random(2'd0, 1);
    send_random(SLOT_SOLVE, 0);
    send_random(2'd1, 1);
    send_random(SLOT_SOLVE, 3);
  endtask

  // Coplanar centres give a zero determinant.
  task automatic test_singular;
    send_sphere(2'd0, 0, 0, 0, (CW-1)'(100));
    send_sphere(2'd1, 32'sh10000, 0, 0, (CW-1)'(200));
    send_sphere(2'd2, 0, 32'sh10000, 0, (CW-1)'(300));
    send_sphere(SLOT_SOLVE, 32'sh10000, 32'sh10000, 0, (CW-1)'(400));
    send_sphere(SLOT_SOLVE, 0, 0, 0, '0);
  endtask

  // A well-posed point, field extremes and reuse of the stored spheres.
  task automatic test_extremes;
    send_sphere(2'd0, 0, 0, 0, (CW-1)'(32'h20000));
    send_sphere(2'd1, 32'sh10000, 0, 0, (CW-1)'(32'h18000));
    send_sphere(2'd2, 0, 32'sh10000, 0, (CW-1)'(32'h18000));
    send_sphere(SLOT_SOLVE, 0, 0, 32'sh10000, (CW-1)'(32'h18000));
    send_sphere(SLOT_SOLVE, 0, 0, -32'sh10000, '1);
    send_sphere(2'd0, {1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}},
                {1'b1, {(CW-1){1'b0}}}, '1);
    send_sphere(2'd1, {1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}, 0, '0);
    send_sphere(2'd2, 0, {1'b0, {(CW-1){1'b1}}}, -1, '1);
    send_sphere(SLOT_SOLVE, -1, 0, {1'b0, {(CW-1){1'b1}}}, '0);
    send_sphere(2'd1, 1, 0, 0, '0);
    send_sphere(2'd2, 0, 1, 0, '0);
    send_sphere(SLOT_SOLVE, 0, 0, 1, '1);
    send_sphere(SLOT_SOLVE, 1, 1, 1, (CW-1)'(1));
  endtask

  // Mostly complete sets followed by solves, with noise and broken sets.
  task automatic test_random;
    int sent, kind;
    sent = 0;
    while (sent < 680) begin
      kind = $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) begin
        send_random(2'($urandom_range(0, 3)), kind);
        sent++;
      end else begin
        for (int s = 0; s < 3; s++) begin
          send_random(2'(s), $urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : kind);
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_random(SLOT_SOLVE, kind);
          sent++;
        end
      end
      if ($urandom_range(0, 15) == 0) drain();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_sphere_slot <= '0;
    in_center_x    <= '0;
    in_center_y    <= '0;
    in_center_z    <= '0;
    in_radius      <= '0;
    sph_loaded     = '0;
    mismatches     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_incomplete();
    test_singular();
    test_extremes();
    drain();
    test_random();

    // Let the last transaction finish, then settle.
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
